// ===== src/cgc_pkg.sv =====
// shared types and constants for the greedy constraint coloring block
package cgc_pkg;

  localparam int unsigned VERTEX_COUNT_DEF = 4096;
  localparam int unsigned MAX_COLORS_DEF   = 32;

  localparam int unsigned VERTEX_W = 12;
  localparam int unsigned COLOR_W  = 5;
  localparam int unsigned USED_W   = 6;

  // vertex slots per constraint, and how many are active in each mode
  localparam int unsigned SLOTS   = 4;
  localparam int unsigned SLOT_W  = 2;
  localparam int unsigned NV_TWO  = 2;
  localparam int unsigned NV_FOUR = 4;

  // set tag stored beside each mask, lets a new set skip clearing the memory
  localparam int unsigned EPOCH_W = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FOUR_VERTEX_MODE = 1'b0;

  typedef logic [VERTEX_W-1:0] vertex_t;

  typedef struct packed {
    logic    new_set;
    vertex_t vertex_a;
    vertex_t vertex_b;
    vertex_t vertex_c;
    vertex_t vertex_d;
  } in_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               no_color_free;
    logic [USED_W-1:0]  colors_used;
  } out_item_t;

  // record of the last colored constraint, used to forward its writes
  typedef struct packed {
    logic                   valid;
    logic [SLOTS-1:0]       en;
    vertex_t [SLOTS-1:0]    vertex;
  } fwd_ctrl_t;

endpackage

// ===== src/cgc_mask_ram.sv =====
// vertex mask memory: one write port, two registered read ports, write-first
module cgc_mask_ram import cgc_pkg::*; #(
  parameter int unsigned DEPTH = VERTEX_COUNT_DEF,
  parameter int unsigned WIDTH = EPOCH_W + MAX_COLORS_DEF
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [$clog2(DEPTH)-1:0]      waddr_i,
  input  logic [WIDTH-1:0]              wdata_i,
  input  logic                          re_i,
  input  logic [1:0][$clog2(DEPTH)-1:0] raddr_i,
  output logic [1:0][WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0]      mem_q [DEPTH];
  logic [1:0][WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // a read at the address being written returns the new word
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      for (int p = 0; p < 2; p++) begin
        if (we_i && (waddr_i == raddr_i[p])) begin
          rdata_q[p] <= wdata_i;
        end else begin
          rdata_q[p] <= mem_q[raddr_i[p]];
        end
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/cgc_select.sv =====
// merges the read masks with forwarding and picks the lowest free color
module cgc_select import cgc_pkg::*; #(
  parameter int unsigned MAX_COLORS = MAX_COLORS_DEF
) (
  input  logic [SLOTS-1:0][EPOCH_W+MAX_COLORS-1:0] rdata_i,
  input  vertex_t [SLOTS-1:0]                      vertex_i,
  input  logic [SLOTS-1:0]                         use_i,
  input  logic [EPOCH_W-1:0]                       epoch_i,
  input  logic                                     new_set_i,
  input  fwd_ctrl_t                                fwd_i,
  input  logic [MAX_COLORS-1:0]                    fwd_bit_i,
  output logic                                     none_o,
  output logic [$clog2(MAX_COLORS)-1:0]            idx_o,
  output logic [MAX_COLORS-1:0]                    bit_o,
  output logic [SLOTS-1:0][MAX_COLORS-1:0]         new_mask_o
);

  localparam int unsigned CW = $clog2(MAX_COLORS);

  logic [SLOTS-1:0][MAX_COLORS-1:0] old_mask;
  logic [SLOTS-1:0]                 hit;
  logic [MAX_COLORS-1:0]            used;
  logic [MAX_COLORS-1:0]            free;

  always_comb begin
    used = '0;
    for (int j = 0; j < SLOTS; j++) begin
      hit[j] = 1'b0;
      // writes of the previous constraint may not have landed yet
      for (int k = 0; k < SLOTS; k++) begin
        if (fwd_i.valid && fwd_i.en[k] && (fwd_i.vertex[k] == vertex_i[j])) begin
          hit[j] = 1'b1;
        end
      end
      old_mask[j] = '0;
      if (use_i[j]) begin
        // an entry tagged with an older set reads as empty
        if (rdata_i[j][EPOCH_W+MAX_COLORS-1:MAX_COLORS] == epoch_i) begin
          old_mask[j] = rdata_i[j][MAX_COLORS-1:0];
        end
        if (hit[j] && !new_set_i) begin
          old_mask[j] = old_mask[j] | fwd_bit_i;
        end
      end
      used = used | old_mask[j];
    end
  end

  assign free   = ~used;
  assign none_o = (free == '0);
  assign bit_o  = free & (~free + MAX_COLORS'(1));

  always_comb begin
    idx_o = '0;
    for (int i = 0; i < MAX_COLORS; i++) begin
      if (bit_o[i]) begin
        idx_o = idx_o | CW'(i);
      end
    end
    for (int j = 0; j < SLOTS; j++) begin
      new_mask_o[j] = old_mask[j] | bit_o;
    end
  end

endmodule

// ===== src/constraint_greedy_coloring.sv =====
// Greedy constraint coloring: each constraint gets the lowest color not yet used at any of
// its vertices in the current set. An accepted transaction reads all vertex masks at once
// from two mirrored mask memories, picks the color from the registered read words and then
// writes the masks back through the single write port, one vertex per cycle. A result is
// registered when its constraint leaves the read stage, which waits while the previous
// constraint still holds the write port or the last result is not yet taken; the write port
// thus sets the sustained rate, and the next constraint is read while the previous one
// still writes, its pending bits being forwarded. After reset the block runs a clearing
// pass over all VERTEX_COUNT addresses before it takes any transaction; a new set only bumps
// an 8-bit set tag, so every 255th new set costs another clearing pass first. Configuration
// writes are accepted at all times but should only be issued while the block is idle.
module constraint_greedy_coloring import cgc_pkg::*; #(
  parameter int unsigned VERTEX_COUNT = VERTEX_COUNT_DEF,
  parameter int unsigned MAX_COLORS   = MAX_COLORS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned AW    = $clog2(VERTEX_COUNT);
  localparam int unsigned MW    = EPOCH_W + MAX_COLORS;
  localparam int unsigned CW    = $clog2(MAX_COLORS);
  localparam int unsigned CNT_W = $clog2(MAX_COLORS + 1);

  // configuration
  logic mode_q;
  logic cfg_wr;

  // clearing pass and set tag
  logic                 clearing_q;
  logic [AW-1:0]        clr_addr_q;
  logic [EPOCH_W-1:0]   epoch_q;

  // read stage
  logic     s1_valid_q;
  in_item_t s1_item_q;

  // write stage and forwarding record
  logic                             s2_busy_q;
  logic [SLOT_W-1:0]                s2_slot_q;
  logic [SLOTS-1:0][AW-1:0]         s2_addr_q;
  logic [SLOTS-1:0][MAX_COLORS-1:0] s2_mask_q;
  logic [EPOCH_W-1:0]               s2_epoch_q;
  fwd_ctrl_t                        fwd_q;
  logic [MAX_COLORS-1:0]            fwd_bit_q;

  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] count_d;
  logic [CNT_W-1:0] count_base;
  logic             out_valid_q;
  out_item_t        out_q;

  logic in_accept;
  logic s1_adv;
  logic s2_last;
  logic clr_start;
  logic clr_done;

  vertex_t [SLOTS-1:0]      in_vtx;
  vertex_t [SLOTS-1:0]      s1_vtx;
  logic [SLOTS-1:0]         s1_use;
  logic [SLOT_W-1:0]        last_slot;

  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic [MW-1:0]            mem_wdata;
  logic [1:0][AW-1:0]       raddr_lo;
  logic [1:0][AW-1:0]       raddr_hi;
  logic [1:0][MW-1:0]       rdata_lo;
  logic [1:0][MW-1:0]       rdata_hi;
  logic [SLOTS-1:0][MW-1:0] rdata;

  logic                             pick_none;
  logic [CW-1:0]                    pick_idx;
  logic [MAX_COLORS-1:0]            pick_bit;
  logic [SLOTS-1:0][MAX_COLORS-1:0] pick_mask;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite
                  && (paddr[CFG_ADDR_W-1:2] == REG_FOUR_VERTEX_MODE);
  always_comb begin
    prdata = '0;
    if (paddr[CFG_ADDR_W-1:2] == REG_FOUR_VERTEX_MODE) begin
      prdata[0] = mode_q;
    end
  end

  assign in_vtx = {in_data_i.vertex_d, in_data_i.vertex_c,
                   in_data_i.vertex_b, in_data_i.vertex_a};
  assign s1_vtx = {s1_item_q.vertex_d, s1_item_q.vertex_c,
                   s1_item_q.vertex_b, s1_item_q.vertex_a};

  always_comb begin
    for (int j = 0; j < SLOTS; j++) begin
      s1_use[j] = (32'(s1_vtx[j]) < VERTEX_COUNT) && ((j < NV_TWO) || mode_q);
    end
  end

  assign last_slot = mode_q ? SLOT_W'(NV_FOUR - 1) : SLOT_W'(NV_TWO - 1);
  assign s2_last   = s2_busy_q && (s2_slot_q == last_slot);
  assign s1_adv    = s1_valid_q && (!s2_busy_q || s2_last) && (!out_valid_q || out_ready_i);
  assign in_ready_o = !clearing_q && (!s1_valid_q || s1_adv)
                      && !(in_data_i.new_set && (epoch_q == EPOCH_MAX));
  assign in_accept = in_valid_i && in_ready_o;

  // out of tags: drain, then wipe the memory before this new set goes in
  assign clr_start = !clearing_q && in_valid_i && in_data_i.new_set
                     && (epoch_q == EPOCH_MAX) && !s1_valid_q && !s2_busy_q;
  assign clr_done  = clearing_q && (clr_addr_q == AW'(VERTEX_COUNT - 1));

  // memory ports
  assign raddr_lo = {AW'(in_vtx[1]), AW'(in_vtx[0])};
  assign raddr_hi = {AW'(in_vtx[3]), AW'(in_vtx[2])};
  assign rdata    = {rdata_hi[1], rdata_hi[0], rdata_lo[1], rdata_lo[0]};

  always_comb begin
    if (clearing_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_q;
      mem_wdata = '0;
    end else begin
      mem_we    = s2_busy_q && fwd_q.en[s2_slot_q];
      mem_waddr = s2_addr_q[s2_slot_q];
      mem_wdata = {s2_epoch_q, s2_mask_q[s2_slot_q]};
    end
  end

  cgc_mask_ram #(
    .DEPTH (VERTEX_COUNT),
    .WIDTH (MW)
  ) u_ram_lo (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (in_accept),
    .raddr_i (raddr_lo),
    .rdata_o (rdata_lo)
  );

  cgc_mask_ram #(
    .DEPTH (VERTEX_COUNT),
    .WIDTH (MW)
  ) u_ram_hi (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (in_accept),
    .raddr_i (raddr_hi),
    .rdata_o (rdata_hi)
  );

  cgc_select #(
    .MAX_COLORS (MAX_COLORS)
  ) u_select (
    .rdata_i    (rdata),
    .vertex_i   (s1_vtx),
    .use_i      (s1_use),
    .epoch_i    (epoch_q),
    .new_set_i  (s1_item_q.new_set),
    .fwd_i      (fwd_q),
    .fwd_bit_i  (fwd_bit_q),
    .none_o     (pick_none),
    .idx_o      (pick_idx),
    .bit_o      (pick_bit),
    .new_mask_o (pick_mask)
  );

  always_comb begin
    count_base = s1_item_q.new_set ? '0 : count_q;
    count_d    = count_base;
    if (!pick_none && (CNT_W'(pick_idx) + CNT_W'(1) > count_base)) begin
      count_d = CNT_W'(pick_idx) + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      clearing_q  <= 1'b1;
      clr_addr_q  <= '0;
      epoch_q     <= '0;
      s1_valid_q  <= 1'b0;
      s2_busy_q   <= 1'b0;
      s2_slot_q   <= '0;
      fwd_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        mode_q <= pwdata[0];
      end

      if (clr_start) begin
        clearing_q <= 1'b1;
        clr_addr_q <= '0;
      end else if (clr_done) begin
        clearing_q <= 1'b0;
        epoch_q    <= '0;
        fwd_q      <= '0;
      end else if (clearing_q) begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end

      if (in_accept) begin
        s1_valid_q <= 1'b1;
        epoch_q    <= epoch_q + EPOCH_W'(in_data_i.new_set);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end

      if (s1_adv) begin
        s2_busy_q    <= 1'b1;
        s2_slot_q    <= '0;
        fwd_q.valid  <= 1'b1;
        fwd_q.en     <= pick_none ? '0 : s1_use;
        fwd_q.vertex <= s1_vtx;
        count_q      <= count_d;
      end else if (s2_busy_q) begin
        if (s2_last) begin
          s2_busy_q <= 1'b0;
        end else begin
          s2_slot_q <= s2_slot_q + SLOT_W'(1);
        end
      end

      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q <= in_data_i;
    end
    if (s1_adv) begin
      for (int j = 0; j < SLOTS; j++) begin
        s2_addr_q[j] <= AW'(s1_vtx[j]);
      end
      s2_mask_q         <= pick_mask;
      s2_epoch_q        <= epoch_q;
      fwd_bit_q         <= pick_bit;
      out_q.color       <= pick_none ? '0 : COLOR_W'(pick_idx);
      out_q.no_color_free <= pick_none;
      out_q.colors_used <= USED_W'(count_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  // the clearing pass owns the write port only while nothing is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> (!s1_valid_q && !s2_busy_q))
    else $error("clearing pass overlaps pipeline activity");

  // the set tag must never wrap without a clearing pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_data_i.new_set) |-> (epoch_q != EPOCH_MAX))
    else $error("set tag wrapped");

  // an assigned color is always below the reported color count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && !pick_none) |=> (CNT_W'($past(pick_idx)) < count_q))
    else $error("color count behind assigned color");

  // a new constraint never enters the write stage while writes are still pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |-> (!s2_busy_q || s2_last))
    else $error("write stage overrun");
`endif

endmodule
